### sv/rat_pkg.sv
// Shared types and constants for the two-level region address translator.
// Used by rat_cell, rat_chain and two_level_region_address_translator.
// No dependencies.
package rat_pkg;

    // Default table depths; the top level hands these down as parameters.
    localparam int XLAT_ENTRIES_DEF = 16;
    localparam int MEM_WINDOWS_DEF  = 8;

    // Index bits a write item carries for each table.
    localparam int XLAT_IDX_W = 4;
    localparam int WIN_IDX_W  = 3;

    // Width of the translation entry count register.
    localparam int COUNT_W = 5;

    // Command codes.
    localparam logic [1:0] CMD_WR_XLAT = 2'd0;
    localparam logic [1:0] CMD_WR_WIN  = 2'd1;
    localparam logic [1:0] CMD_XLAT    = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_NO_XLAT = 2'd2;
    localparam logic [1:0] ST_NO_WIN  = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         index;
        logic [31:0]        dev_addr;
        logic [31:0]        sys_base;
        logic [31:0]        region_size;
        logic [31:0]        host_addr;
        logic signed [31:0] length;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] sys_result;
        logic [31:0] host_result;
    } out_t;

    // Entry write: region base, region size and the base it maps onto.
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] size;
        logic [31:0] target;
    } wr_t;

    // Lookup token that walks along a chain of cells.
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [31:0] addr;
        logic [32:0] addr_end;
        logic [31:0] result;
    } tok_t;

endpackage

### sv/two_level_region_address_translator.sv
// Top level of the two-level region address translator.
// Depends on rat_pkg, rat_chain and rat_cell.
//
// Usage:
// Input transfers (in_valid/in_ready, payload in_data) carry one command each:
// write a translation entry, write a memory window, or translate an address.
// Every command gives exactly one output transfer (out_valid/out_ready,
// payload out_data). Writes and rejected translations (zero or negative
// length, unused command) go straight to the done state and raise
// out_valid when the result moves on into the free output register.
// A translation walks a token through a chain of XLAT_ENTRIES cells, one
// cell per cycle, and on a hit then through a chain of MEM_WINDOWS cells.
// One command is handled at a time; in_ready rises again together with
// out_valid, when the result has moved into the output register, so a
// result waiting on out_ready does not hold off the next command.
// When the receiver stalls, out_data is held until taken; a later result
// waits in an internal register and in_ready stays low meanwhile.
// Reset clears the window valid bits, the entry count register and all
// handshake state. Table contents are undefined until written. Write the
// count register (cfg_we/cfg_wdata) only while idle; it is not enforced.
module two_level_region_address_translator #(
    parameter int XLAT_ENTRIES = rat_pkg::XLAT_ENTRIES_DEF,
    parameter int MEM_WINDOWS  = rat_pkg::MEM_WINDOWS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rat_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rat_pkg::out_t                out_data,
    input  logic                         cfg_we,
    input  logic [rat_pkg::COUNT_W-1:0]  cfg_wdata
);
    import rat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_XLAT = 2'd1;
    localparam logic [1:0] S_WIN  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg,  state_next;
    logic [COUNT_W-1:0] xlat_count_reg;
    logic [MEM_WINDOWS-1:0] win_valid_reg;
    tok_t               xinj_reg,   xinj_next;
    tok_t               winj_reg,   winj_next;
    logic [30:0]        len_reg,    len_next;
    logic [31:0]        sys_reg,    sys_next;
    out_t               res_reg,    res_next;
    out_t               out_reg,    out_next;
    logic               out_valid_reg, out_valid_next;

    tok_t               xout;
    tok_t               wout;
    logic               accept;
    logic               bad_len;
    logic               xwr_en;
    logic               wwr_en;
    wr_t                xwr;
    wr_t                wwr;
    logic [XLAT_ENTRIES-1:0] xactive;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A length is bad when the sign bit is set or it is zero.
    assign bad_len = in_data.length[31] || (in_data.length == 32'sd0);

    assign xwr_en = accept && (in_data.cmd == CMD_WR_XLAT);
    assign wwr_en = accept && (in_data.cmd == CMD_WR_WIN);

    assign xwr = '{base: in_data.dev_addr, size: in_data.region_size,
                   target: in_data.sys_base};
    assign wwr = '{base: in_data.sys_base, size: in_data.region_size,
                   target: in_data.host_addr};

    // Only the first xlat_count entries take part in a search. A count
    // above the table depth simply enables every cell.
    for (genvar i = 0; i < XLAT_ENTRIES; i++)
    begin : g_xact
        assign xactive[i] = (32'(xlat_count_reg) > i);
    end

    rat_chain #(
        .N     (XLAT_ENTRIES),
        .IDX_W (XLAT_IDX_W)
    ) u_xlat_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (xwr_en),
        .wr_idx  (in_data.index),
        .wr      (xwr),
        .active  (xactive),
        .tok_in  (xinj_reg),
        .tok_out (xout)
    );

    // Windows are addressed by the low index bits; an unwritten window
    // never matches because its valid bit is clear.
    rat_chain #(
        .N     (MEM_WINDOWS),
        .IDX_W (WIN_IDX_W)
    ) u_win_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wwr_en),
        .wr_idx  (in_data.index[WIN_IDX_W-1:0]),
        .wr      (wwr),
        .active  (win_valid_reg),
        .tok_in  (winj_reg),
        .tok_out (wout)
    );

    always_comb
    begin
        state_next       = state_reg;
        xinj_next        = xinj_reg;
        xinj_next.valid  = 1'b0;
        winj_next        = winj_reg;
        winj_next.valid  = 1'b0;
        len_next         = len_reg;
        sys_next         = sys_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((in_data.cmd == CMD_XLAT) && !bad_len)
                    begin
                        xinj_next.valid    = 1'b1;
                        xinj_next.hit      = 1'b0;
                        xinj_next.addr     = in_data.dev_addr;
                        xinj_next.addr_end = {1'b0, in_data.dev_addr} +
                                             {1'b0, in_data.length};
                        xinj_next.result   = '0;
                        len_next           = in_data.length[30:0];
                        state_next         = S_XLAT;
                    end
                    else
                    begin
                        res_next = '0;
                        if (in_data.cmd == CMD_XLAT)
                        begin
                            res_next.status = ST_BAD_LEN;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_XLAT:
            begin
                if (xout.valid)
                begin
                    if (xout.hit)
                    begin
                        // Second level: look the system address up in
                        // the window chain with the same length.
                        winj_next.valid    = 1'b1;
                        winj_next.hit      = 1'b0;
                        winj_next.addr     = xout.result;
                        winj_next.addr_end = {1'b0, xout.result} +
                                             {2'b00, len_reg};
                        winj_next.result   = '0;
                        sys_next           = xout.result;
                        state_next         = S_WIN;
                    end
                    else
                    begin
                        res_next        = '0;
                        res_next.status = ST_NO_XLAT;
                        state_next      = S_DONE;
                    end
                end
            end
            S_WIN:
            begin
                if (wout.valid)
                begin
                    res_next.sys_result = sys_reg;
                    if (wout.hit)
                    begin
                        res_next.status      = ST_OK;
                        res_next.host_result = wout.result;
                    end
                    else
                    begin
                        res_next.status      = ST_NO_WIN;
                        res_next.host_result = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Move the result on once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            xlat_count_reg <= '0;
            win_valid_reg  <= '0;
            xinj_reg       <= '0;
            winj_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            xinj_reg      <= xinj_next;
            winj_reg      <= winj_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                xlat_count_reg <= cfg_wdata;
            end
            for (int w = 0; w < MEM_WINDOWS; w++)
            begin
                if (wwr_en && (32'(in_data.index[WIN_IDX_W-1:0]) == w))
                begin
                    win_valid_reg[w] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        sys_reg <= sys_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // A token leaves the translation chain only while the walk waits on it.
    a_xout_in_xlat: assert property (@(posedge clk) disable iff (!rst_n)
        xout.valid |-> (state_reg == S_XLAT))
        else $error("translation token left the chain outside the walk");

    // Likewise for the window chain.
    a_wout_in_win: assert property (@(posedge clk) disable iff (!rst_n)
        wout.valid |-> (state_reg == S_WIN))
        else $error("window token left the chain outside the walk");

    // A host address is only reported for a full success.
    a_host_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != ST_OK)) |->
            (out_reg.host_result == '0))
        else $error("host address reported on a failed translation");

    // A good translate command starts a walk on the next cycle.
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.cmd == CMD_XLAT) && !bad_len) |=>
            (xinj_reg.valid && (state_reg == S_XLAT)))
        else $error("translate command did not start a walk");

endmodule

### sv/rat_cell.sv
// One cell of a lookup chain: holds a single region entry and checks the
// passing token against it. Depends on rat_pkg.
module rat_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  rat_pkg::wr_t  wr,
    input  logic          active,
    input  rat_pkg::tok_t tok_in,
    output rat_pkg::tok_t tok_out
);
    import rat_pkg::*;

    logic [31:0] base_reg;
    logic [32:0] end_reg;
    logic [31:0] delta_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        match;

    // The end and the base offset are formed when the entry is written, so
    // the lookup itself needs only two compares and one add.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            base_reg  <= wr.base;
            end_reg   <= {1'b0, wr.base} + {1'b0, wr.size};
            delta_reg <= wr.target - wr.base;
        end
    end

    assign match = tok_in.valid && !tok_in.hit && active &&
                   (tok_in.addr >= base_reg) && (tok_in.addr_end <= end_reg);

    always_comb
    begin
        tok_next = tok_in;
        if (match)
        begin
            tok_next.hit    = 1'b1;
            tok_next.result = tok_in.addr + delta_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### sv/rat_chain.sv
// A row of rat_cell instances; a token advances one cell per cycle.
// Depends on rat_pkg and rat_cell.
module rat_chain #(
    parameter int N     = rat_pkg::XLAT_ENTRIES_DEF,
    parameter int IDX_W = rat_pkg::XLAT_IDX_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  rat_pkg::wr_t     wr,
    input  logic [N-1:0]     active,
    input  rat_pkg::tok_t    tok_in,
    output rat_pkg::tok_t    tok_out
);
    import rat_pkg::*;

    tok_t tok_link [N+1];

    assign tok_link[0] = tok_in;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic cell_wr_en;

        // Cells beyond the reach of the index field are never written.
        assign cell_wr_en = wr_en && (32'(wr_idx) == i);

        rat_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (cell_wr_en),
            .wr      (wr),
            .active  (active[i]),
            .tok_in  (tok_link[i]),
            .tok_out (tok_link[i+1])
        );
    end

    assign tok_out = tok_link[N];

endmodule
